>>> hdl/snoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snoc_pkg;

   // Fixed field widths of the datapath.
   localparam int CMD_BITS  = 16;
   localparam int TIME_BITS = 32;
   localparam int CFG_BITS  = 16;

   // Default width of the sample counter.
   localparam int DEF_COUNT_BITS = 16;

   // Configuration port geometry and reset values.
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 16'd2000;
   localparam logic [CFG_BITS-1:0] ABORT_RESET  = 16'd300;

   // Register indexes, taken from the word address bit.
   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_ABORT  = 1'b1;

   // Input word actions.
   localparam logic ACT_RESTART = 1'b0;
   localparam logic ACT_SAMPLE  = 1'b1;

   typedef struct packed {
      logic                       action;
      logic [TIME_BITS-1:0]       now_ms;
      logic                       remote_present;
      logic signed [CMD_BITS-1:0] command_left;
      logic signed [CMD_BITS-1:0] command_right;
   } snoc_req_type;

   typedef struct packed {
      logic signed [CMD_BITS-1:0] adjusted_left;
      logic signed [CMD_BITS-1:0] adjusted_right;
      logic                       force_zero_drive;
      logic                       phase_now;
      logic                       abort_seen;
      logic signed [CMD_BITS-1:0] offset_left;
      logic signed [CMD_BITS-1:0] offset_right;
      logic [TIME_BITS-1:0]       elapsed_ms;
   } snoc_rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] window_ms;
      logic [CFG_BITS-1:0] abort_mag;
   } snoc_cfg_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
      logic start;
   } snoc_lane_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } snoc_lane_stat_type;

endpackage

`default_nettype wire

>>> hdl/startup_neutral_offset_calibrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Startup neutral-offset calibrator. A restart word (action 0) records now_ms
// as the start time and clears the calibration; it returns no word. Each
// sample word (action 1) returns one result word. While the observation
// window runs, the result asks for zero drive, and the block latches an
// abort when either command magnitude reaches abort_magnitude, notes any
// sample without the remote link, and sums both commands over the samples
// that had the link. The sample whose elapsed time reaches observe_window_ms
// ends the window: if nothing aborted, the link stayed up and at least one
// sample was counted, the left and right lanes each divide their sum by the
// sample count, truncated toward zero, to form the neutral offsets;
// otherwise the offsets stay zero. Afterwards each result carries the
// commands minus the offsets, wrapped to 16 bits. A restart leaves the
// block ready for the next word in the following cycle; an ordinary sample
// waits in the held slot until its result moves into the output register,
// which holds it while the next word is taken in. The sample that ends the
// window with offsets to compute waits for the bit-serial restoring divider
// in each lane, which retires one quotient bit per cycle over the sum of
// 16 + COUNT_BITS bits. Registers sit at byte address 0 (observe_window_ms)
// and 4 (abort_magnitude) and may be written only while no word is in
// flight.
module startup_neutral_offset_calibrator #(
   parameter int COUNT_BITS = snoc_pkg::DEF_COUNT_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire snoc_pkg::snoc_req_type         req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output snoc_pkg::snoc_rsp_type              rsp_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [snoc_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [snoc_pkg::DATA_BITS-1:0] pwdata,
   output logic      [snoc_pkg::DATA_BITS-1:0] prdata,
   output logic                                pready
);
   import snoc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DIVIDE = 1'b1;

   snoc_cfg_type       cfg;
   snoc_lane_ctl_type  lane_ctl;
   snoc_lane_stat_type stat_left;
   snoc_lane_stat_type stat_right;
   logic signed [CMD_BITS-1:0] neutral_left;
   logic signed [CMD_BITS-1:0] neutral_right;

   // Calibration state.
   logic                       state_ff, state_in;
   logic [TIME_BITS-1:0]       start_time_ff, start_time_in;
   logic                       run_phase_ff, run_phase_in;
   logic                       present_ff, present_in;
   logic                       abort_ff, abort_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;

   // The accepted sample waits here until its result can be formed and sent.
   logic                       held_valid_ff, held_valid_in;
   logic signed [CMD_BITS-1:0] held_left_ff, held_left_in;
   logic signed [CMD_BITS-1:0] held_right_ff, held_right_in;
   logic [TIME_BITS-1:0]       held_elapsed_ff, held_elapsed_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   snoc_rsp_type               rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       is_sample;
   logic                       observe_accept;
   logic [TIME_BITS-1:0]       elapsed;
   logic [CMD_BITS:0]          ext_left, ext_right;
   logic [CMD_BITS:0]          mag_left, mag_right;
   logic                       over_limit;
   logic                       present_next;
   logic                       abort_next;
   logic                       take;
   logic                       window_done;
   logic                       eligible;
   logic                       move_out;
   snoc_rsp_type               formed;

   snoc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Only one word waits in the held slot at a time; the slot frees as soon as its
   // result moves into the output register.
   assign req_ready      = (state_ff == ST_IDLE) && !held_valid_ff;
   assign accept         = req_valid && req_ready;
   assign is_sample      = (req_data.action == ACT_SAMPLE);
   assign observe_accept = accept && is_sample && !run_phase_ff;

   assign elapsed = req_data.now_ms - start_time_ff;

   // Magnitudes in 17 bits so that the most negative command reads as 32768.
   assign ext_left  = {req_data.command_left[CMD_BITS-1], req_data.command_left};
   assign ext_right = {req_data.command_right[CMD_BITS-1], req_data.command_right};
   assign mag_left  = ext_left[CMD_BITS] ? (~ext_left + 1'b1) : ext_left;
   assign mag_right = ext_right[CMD_BITS] ? (~ext_right + 1'b1) : ext_right;
   assign over_limit = (mag_left >= {1'b0, cfg.abort_mag}) ||
                       (mag_right >= {1'b0, cfg.abort_mag});

   assign present_next = present_ff && req_data.remote_present;
   assign abort_next   = abort_ff || over_limit;
   // Once the count saturates, the sums stop growing as well.
   assign take         = req_data.remote_present && (count_ff != '1);
   assign window_done  = elapsed >= {{(TIME_BITS-CFG_BITS){1'b0}}, cfg.window_ms};
   assign eligible     = present_next && !abort_next && ((count_ff != '0) || take);

   assign lane_ctl.clear      = accept && !is_sample;
   assign lane_ctl.accumulate = observe_accept && take;
   assign lane_ctl.start      = observe_accept && window_done && eligible;

   snoc_lane #(
      .COUNT_BITS (COUNT_BITS)
   ) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .command (req_data.command_left),
      .divisor (count_ff),
      .stat    (stat_left),
      .neutral (neutral_left)
   );

   snoc_lane #(
      .COUNT_BITS (COUNT_BITS)
   ) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .command (req_data.command_right),
      .divisor (count_ff),
      .stat    (stat_right),
      .neutral (neutral_right)
   );

   // Merge stage: the held sample and the lane offsets form the result word.
   always_comb begin
      formed.adjusted_left    = run_phase_ff ? (held_left_ff - neutral_left) : held_left_ff;
      formed.adjusted_right   = run_phase_ff ? (held_right_ff - neutral_right) : held_right_ff;
      formed.force_zero_drive = !run_phase_ff;
      formed.phase_now        = run_phase_ff;
      formed.abort_seen       = abort_ff;
      formed.offset_left      = neutral_left;
      formed.offset_right     = neutral_right;
      formed.elapsed_ms       = held_elapsed_ff;
   end

   assign move_out = held_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      start_time_in   = start_time_ff;
      run_phase_in    = run_phase_ff;
      present_in      = present_ff;
      abort_in        = abort_ff;
      count_in        = count_ff;
      held_valid_in   = held_valid_ff;
      held_left_in    = held_left_ff;
      held_right_in   = held_right_ff;
      held_elapsed_in = held_elapsed_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;

      if (move_out) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = formed;
         held_valid_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept && !is_sample) begin
         start_time_in = req_data.now_ms;
         run_phase_in  = 1'b0;
         present_in    = 1'b1;
         abort_in      = 1'b0;
         count_in      = '0;
      end

      if (observe_accept) begin
         present_in = present_next;
         abort_in   = abort_next;
         if (take) begin
            count_in = count_ff + 1'b1;
         end
         if (window_done) begin
            run_phase_in = 1'b1;
         end
      end

      if (accept && is_sample) begin
         held_left_in    = req_data.command_left;
         held_right_in   = req_data.command_right;
         held_elapsed_in = elapsed;
         held_valid_in   = !lane_ctl.start;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (lane_ctl.start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Both lanes run in lockstep, so the left lane marks the end.
            if (stat_left.done) begin
               state_in      = ST_IDLE;
               held_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         start_time_ff <= '0;
         run_phase_ff  <= 1'b0;
         present_ff    <= 1'b1;
         abort_ff      <= 1'b0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_time_ff <= start_time_in;
         run_phase_ff  <= run_phase_in;
         present_ff    <= present_in;
         abort_ff      <= abort_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_left_ff    <= held_left_in;
      held_right_ff   <= held_right_in;
      held_elapsed_ff <= held_elapsed_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The two lanes start together and have the same latency.
   assert property (@(posedge clock) disable iff (reset)
      (stat_left.busy == stat_right.busy) && (stat_left.done == stat_right.done))
      else $error("calibration lanes out of step");

   // Offsets stay zero until the observation window has ended.
   assert property (@(posedge clock) disable iff (reset)
      !run_phase_ff |-> (neutral_left == '0) && (neutral_right == '0))
      else $error("nonzero offset while observing");

   // No result is pending while the dividers are still working.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !held_valid_ff && stat_left.busy)
      else $error("result pending during offset division");

   // A result asks for zero drive exactly when it was produced while observing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.force_zero_drive != rsp_data.phase_now))
      else $error("drive hold and phase disagree");

   // The sample count is never zero while a division runs.
   assert property (@(posedge clock) disable iff (reset)
      stat_left.busy |-> (count_ff != '0))
      else $error("division started with an empty sample count");
`endif

endmodule

`default_nettype wire

>>> hdl/snoc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module snoc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [snoc_pkg::ADDR_BITS-1:0]      paddr,
   input  wire logic [snoc_pkg::DATA_BITS-1:0]      pwdata,
   output logic      [snoc_pkg::DATA_BITS-1:0]      prdata,
   output logic                                     pready,
   output snoc_pkg::snoc_cfg_type                   cfg
);
   import snoc_pkg::*;

   logic [CFG_BITS-1:0] window_ff, window_in;
   logic [CFG_BITS-1:0] abort_ff, abort_in;
   logic                write_en;
   logic                reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[ADDR_BITS-1];

   always_comb begin
      window_in = window_ff;
      abort_in  = abort_ff;
      prdata    = '0;
      unique case (reg_index)
         CSR_WINDOW: begin
            prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, window_ff};
            if (write_en) begin
               window_in = pwdata[CFG_BITS-1:0];
            end
         end
         CSR_ABORT: begin
            prdata = {{(DATA_BITS-CFG_BITS){1'b0}}, abort_ff};
            if (write_en) begin
               abort_in = pwdata[CFG_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         abort_ff  <= ABORT_RESET;
      end else begin
         window_ff <= window_in;
         abort_ff  <= abort_in;
      end
   end

   assign cfg.window_ms = window_ff;
   assign cfg.abort_mag = abort_ff;

endmodule

`default_nettype wire

>>> hdl/snoc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One command lane: a signed running sum and a bit-serial restoring divider
// that turns the sum into the neutral offset, truncated toward zero.
module snoc_lane #(
   parameter int COUNT_BITS = snoc_pkg::DEF_COUNT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire snoc_pkg::snoc_lane_ctl_type         ctl,
   input  wire logic signed [snoc_pkg::CMD_BITS-1:0] command,
   input  wire logic [COUNT_BITS-1:0]               divisor,
   output snoc_pkg::snoc_lane_stat_type             stat,
   output logic signed [snoc_pkg::CMD_BITS-1:0]     neutral
);
   import snoc_pkg::*;

   localparam int SUM_BITS  = CMD_BITS + COUNT_BITS;
   localparam int STEP_BITS = $clog2(SUM_BITS + 1);

   localparam logic [1:0] LS_IDLE   = 2'd0;
   localparam logic [1:0] LS_LOAD   = 2'd1;
   localparam logic [1:0] LS_STEP   = 2'd2;
   localparam logic [1:0] LS_FINISH = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS:0]        rem_ff, rem_in;
   logic [SUM_BITS-1:0]        quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic signed [CMD_BITS-1:0] neutral_ff, neutral_in;

   logic [SUM_BITS-1:0]        sum_ext;
   logic [COUNT_BITS:0]        shifted;
   logic [COUNT_BITS+1:0]      trial;
   logic [CMD_BITS-1:0]        qmag;

   assign sum_ext = {{COUNT_BITS{command[CMD_BITS-1]}}, command};
   assign shifted = {rem_ff[COUNT_BITS-1:0], quo_ff[SUM_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};
   assign qmag    = quo_ff[CMD_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      sum_in     = sum_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      step_in    = step_ff;
      neutral_in = neutral_ff;
      if (ctl.clear) begin
         sum_in     = '0;
         neutral_in = '0;
         state_in   = LS_IDLE;
      end else begin
         unique case (state_ff)
            LS_IDLE: begin
               if (ctl.accumulate) begin
                  sum_in = sum_ff + $signed(sum_ext);
               end
               if (ctl.start) begin
                  state_in = LS_LOAD;
               end
            end
            LS_LOAD: begin
               // Divide magnitudes; the sign goes back on at the end.
               neg_in   = sum_ff[SUM_BITS-1];
               quo_in   = sum_ff[SUM_BITS-1] ? (~sum_ff + 1'b1) : sum_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = LS_STEP;
            end
            LS_STEP: begin
               if (!trial[COUNT_BITS+1]) begin
                  rem_in = trial[COUNT_BITS:0];
                  quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
                  state_in = LS_FINISH;
               end
            end
            LS_FINISH: begin
               neutral_in = neg_ff ? (~qmag + 1'b1) : qmag;
               state_in   = LS_IDLE;
            end
            default: begin
               state_in = LS_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LS_IDLE;
         sum_ff     <= '0;
         neutral_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         neutral_ff <= neutral_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   assign stat.busy = (state_ff != LS_IDLE);
   assign stat.done = (state_ff == LS_FINISH);
   assign neutral   = neutral_ff;

endmodule

`default_nettype wire
